### src/sstf_pkg.sv
// Shared types, codes and widths for the SSTF request scheduler.
package sstf_pkg;

  localparam int unsigned SECTOR_W  = 48;
  localparam int unsigned TAG_W     = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned ENTRY_W   = SECTOR_W + TAG_W;
  localparam int unsigned DEPTH_DEF = 16;

  localparam logic [KIND_W-1:0] KIND_ADD      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTAG      = 3'd5;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_REMOVE   = 2'd2
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [SECTOR_W-1:0] position;
    logic [TAG_W-1:0]    tag;
  } req_t;

endpackage

### src/sstf_request_scheduler_core.sv
// Top level of the SSTF request scheduler: front queue, back end and checks.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  kind_i, position_i, tag_i
//   out      output     out_valid_o / out_stall_i status_o, out_position_o, out_tag_o, pending_o
//   cfg      input      cfg_we_i                 cfg_initial_head_i
//
// Add, full refusal, empty dispatch or remove: the back end goes from idle straight to S_OUT,
// which loads the output register. Dispatch and remove with N pending scan all N entries, one
// memory read per cycle; a dispatch or found tag then moves each entry after the chosen one down.
// Reset clears the count and head; the request memory needs no clearing pass.
// A two-entry queue holds accepted items while the back end or the output is stalled.
module sstf_request_scheduler_core
  import sstf_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [SECTOR_W-1:0] position_i,
  input  logic [TAG_W-1:0]    tag_i,
  input  logic                cfg_we_i,
  input  logic [SECTOR_W-1:0] cfg_initial_head_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SECTOR_W-1:0] out_position_o,
  output logic [TAG_W-1:0]    out_tag_o,
  output logic [CW-1:0]       pending_o
);

  logic req_valid;
  logic req_stall;
  req_t req;

  sstf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .position_i  (position_i),
    .tag_i       (tag_i),
    .req_valid_o (req_valid),
    .req_stall_i (req_stall),
    .req_o       (req)
  );

  sstf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_initial_head_i (cfg_initial_head_i),
    .req_valid_i        (req_valid),
    .req_stall_o        (req_stall),
    .req_i              (req),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .out_position_o     (out_position_o),
    .out_tag_o          (out_tag_o),
    .pending_o          (pending_o)
  );

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_o <= CW'(DEPTH)))
    else $error("pending count exceeds table depth");

  a_full_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |-> (pending_o == CW'(DEPTH)))
    else $error("full refusal with free entries");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EMPTY))
      |-> ((pending_o == '0) && (out_position_o == '0) && (out_tag_o == '0)))
    else $error("empty dispatch with nonzero fields");

  a_added_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_ADDED)) |-> (pending_o != '0))
    else $error("added request not counted");

  a_back_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && !req_stall) |=> req_stall)
    else $error("back end took a request without going busy");

endmodule

### src/sstf_front.sv
// Front end: accepts input items, classifies them and queues those of a known kind for the back end.
module sstf_front
  import sstf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [SECTOR_W-1:0] position_i,
  input  logic [TAG_W-1:0]    tag_i,
  output logic                req_valid_o,
  input  logic                req_stall_i,
  output req_t                req_o
);

  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  req_t       queue_q [2];
  logic       cls_ok;
  op_e        cls_op;
  logic       push, pop;

  always_comb begin
    cls_ok = 1'b1;
    cls_op = OP_ADD;
    case (kind_i)
      KIND_ADD:      cls_op = OP_ADD;
      KIND_DISPATCH: cls_op = OP_DISPATCH;
      KIND_REMOVE:   cls_op = OP_REMOVE;
      default:       cls_ok = 1'b0;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = queue_q[rp_q];
  assign push        = in_valid_i && !in_stall_o && cls_ok;
  assign pop         = req_valid_o && !req_stall_i;
  assign cnt_d       = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wp_q] <= '{op: cls_op, position: position_i, tag: tag_i};
    end
  end

endmodule

### src/sstf_back.sv
// Back end: request table memory, nearest and tag scans, compaction and result register.
module sstf_back
  import sstf_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SECTOR_W-1:0] cfg_initial_head_i,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  req_t                req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SECTOR_W-1:0] out_position_o,
  output logic [TAG_W-1:0]    out_tag_o,
  output logic [CW-1:0]       pending_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_OUT    = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [SECTOR_W-1:0] head_q, head_d;
  logic [CW-1:0]       scan_q, scan_d, scan_nx;
  logic [CW-1:0]       sh_q, sh_d, sh_nx;
  logic                found_q, found_d;
  op_e                 op_q, op_d;
  logic [TAG_W-1:0]    op_tag_q, op_tag_d;

  logic [ENTRY_W-1:0]  mem_q [DEPTH];
  logic [ENTRY_W-1:0]  rd_data_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_wa, mem_ra;
  logic [ENTRY_W-1:0]  mem_wd;

  logic                s1_valid_q, s1_valid_d;
  logic [AW-1:0]       s1_idx_q, s1_idx_d;
  logic                s1_last_q, s1_last_d;

  logic                s2_valid_q;
  logic [AW-1:0]       s2_idx_q;
  logic                s2_last_q;
  logic [SECTOR_W-1:0] s2_seek_q;
  logic                s2_match_q;
  logic [SECTOR_W-1:0] s2_sector_q;
  logic [TAG_W-1:0]    s2_tag_q;

  logic [SECTOR_W-1:0] rd_sector;
  logic [TAG_W-1:0]    rd_tag;
  logic [SECTOR_W:0]   diff_fwd;
  logic [SECTOR_W-1:0] seek_len;

  logic [AW-1:0]       best_idx_q, best_idx_d;
  logic [SECTOR_W-1:0] best_seek_q, best_seek_d;
  logic [SECTOR_W-1:0] best_sector_q, best_sector_d;
  logic [TAG_W-1:0]    best_tag_q, best_tag_d;

  logic                wpend_q, wpend_d;
  logic [AW-1:0]       wpend_addr_q, wpend_addr_d;

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [SECTOR_W-1:0] res_pos_q, res_pos_d;
  logic [TAG_W-1:0]    res_tag_q, res_tag_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SECTOR_W-1:0] out_pos_q;
  logic [TAG_W-1:0]    out_tag_q;
  logic [CW-1:0]       out_pending_q;
  logic                out_load;

  assign scan_nx   = scan_q + CW'(1);
  assign sh_nx     = sh_q + CW'(1);
  assign rd_sector = rd_data_q[ENTRY_W-1:TAG_W];
  assign rd_tag    = rd_data_q[TAG_W-1:0];
  assign diff_fwd  = {1'b0, rd_sector} - {1'b0, head_q};
  assign seek_len  = diff_fwd[SECTOR_W] ? (head_q - rd_sector) : diff_fwd[SECTOR_W-1:0];

  assign req_stall_o    = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_position_o = out_pos_q;
  assign out_tag_o      = out_tag_q;
  assign pending_o      = out_pending_q;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    head_d        = head_q;
    scan_d        = scan_q;
    sh_d          = sh_q;
    found_d       = found_q;
    op_d          = op_q;
    op_tag_d      = op_tag_q;
    res_status_d  = res_status_q;
    res_pos_d     = res_pos_q;
    res_tag_d     = res_tag_q;
    best_idx_d    = best_idx_q;
    best_seek_d   = best_seek_q;
    best_sector_d = best_sector_q;
    best_tag_d    = best_tag_q;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_re        = 1'b0;
    mem_ra        = '0;
    s1_valid_d    = 1'b0;
    s1_idx_d      = s1_idx_q;
    s1_last_d     = s1_last_q;
    wpend_d       = 1'b0;
    wpend_addr_d  = wpend_addr_q;
    out_load      = 1'b0;

    if (cfg_we_i) begin
      head_d = cfg_initial_head_i;
    end

    if (s2_valid_q) begin
      if (op_q == OP_DISPATCH) begin
        if ((s2_idx_q == '0) || (s2_seek_q < best_seek_q)) begin
          best_idx_d    = s2_idx_q;
          best_seek_d   = s2_seek_q;
          best_sector_d = s2_sector_q;
          best_tag_d    = s2_tag_q;
        end
      end else if (s2_match_q && !found_q) begin
        found_d    = 1'b1;
        best_idx_d = s2_idx_q;
        best_tag_d = s2_tag_q;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d      = req_i.op;
          op_tag_d  = req_i.tag;
          res_pos_d = '0;
          res_tag_d = '0;
          case (req_i.op)
            OP_ADD: begin
              if (count_q == CW'(DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                mem_we       = 1'b1;
                mem_wa       = count_q[AW-1:0];
                mem_wd       = {req_i.position, req_i.tag};
                count_d      = count_q + CW'(1);
                res_status_d = ST_ADDED;
              end
              state_d = S_OUT;
            end
            OP_DISPATCH, OP_REMOVE: begin
              if (count_q == '0) begin
                res_status_d = (req_i.op == OP_DISPATCH) ? ST_EMPTY : ST_NOTAG;
                state_d      = S_OUT;
              end else begin
                scan_d  = '0;
                found_d = 1'b0;
                state_d = S_SCAN;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_q != count_q) begin
          mem_re     = 1'b1;
          mem_ra     = scan_q[AW-1:0];
          s1_valid_d = 1'b1;
          s1_idx_d   = scan_q[AW-1:0];
          s1_last_d  = (scan_nx == count_q);
          scan_d     = scan_nx;
        end
        if (s2_valid_q && s2_last_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        sh_d = CW'(best_idx_q);
        if (op_q == OP_DISPATCH) begin
          head_d       = best_sector_q;
          res_status_d = ST_DISPATCHED;
          res_pos_d    = best_sector_q;
          res_tag_d    = best_tag_q;
          state_d      = S_SHIFT;
        end else if (found_q) begin
          res_status_d = ST_REMOVED;
          res_tag_d    = best_tag_q;
          state_d      = S_SHIFT;
        end else begin
          res_status_d = ST_NOTAG;
          state_d      = S_OUT;
        end
      end
      S_SHIFT: begin
        if (wpend_q) begin
          mem_we = 1'b1;
          mem_wa = wpend_addr_q;
          mem_wd = rd_data_q;
        end
        if (sh_nx != count_q) begin
          mem_re       = 1'b1;
          mem_ra       = sh_nx[AW-1:0];
          wpend_d      = 1'b1;
          wpend_addr_d = sh_q[AW-1:0];
          sh_d         = sh_nx;
        end else if (!wpend_q) begin
          count_d = count_q - CW'(1);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      scan_q      <= '0;
      sh_q        <= '0;
      found_q     <= 1'b0;
      op_q        <= OP_ADD;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      wpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      head_q     <= head_d;
      scan_q     <= scan_d;
      sh_q       <= sh_d;
      found_q    <= found_d;
      op_q       <= op_d;
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
      wpend_q    <= wpend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_tag_q      <= op_tag_d;
    s1_idx_q      <= s1_idx_d;
    s1_last_q     <= s1_last_d;
    best_idx_q    <= best_idx_d;
    best_seek_q   <= best_seek_d;
    best_sector_q <= best_sector_d;
    best_tag_q    <= best_tag_d;
    wpend_addr_q  <= wpend_addr_d;
    res_status_q  <= res_status_d;
    res_pos_q     <= res_pos_d;
    res_tag_q     <= res_tag_d;
    if (s1_valid_q) begin
      s2_idx_q    <= s1_idx_q;
      s2_last_q   <= s1_last_q;
      s2_seek_q   <= seek_len;
      s2_match_q  <= (rd_tag == op_tag_q);
      s2_sector_q <= rd_sector;
      s2_tag_q    <= rd_tag;
    end
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_pos_q     <= res_pos_q;
      out_tag_q     <= res_tag_q;
      out_pending_q <= count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_ra];
    end
  end

endmodule
